[design/ssm_pkg.sv]
// Shared constants, command codes and status types of the sample stability monitor.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package ssm_pkg;

	localparam int WINDOW_LEN_DEF   = 10;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int MAX_COUNT_DEF    = 65536;

	localparam int SUM_W    = 48;
	localparam int DATA_W   = 32;
	localparam int APB_AW   = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [DATA_W-1:0] THRESHOLD_RST = 32'd256;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_STOP   = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CHECK     = 1'b1;

	typedef struct packed {
		logic full;
		logic busy;
		logic stable;
	} ssm_win_stat_t;

endpackage

[design/ssm_cell.sv]
// One window cell: holds one sample, shifts toward the head, and folds its
// sample into the min/max pair passing down the chain. Depends on ssm_pkg.
`timescale 1ns / 1ps

module ssm_cell
	import ssm_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift,
	input  logic signed [SAMPLE_WIDTH-1:0] shift_in,
	output logic signed [SAMPLE_WIDTH-1:0] value,
	input  logic                           scan_vld_in,
	input  logic signed [SAMPLE_WIDTH-1:0] lo_in,
	input  logic signed [SAMPLE_WIDTH-1:0] hi_in,
	output logic                           scan_vld,
	output logic signed [SAMPLE_WIDTH-1:0] lo_out,
	output logic signed [SAMPLE_WIDTH-1:0] hi_out
);

	logic signed [SAMPLE_WIDTH-1:0] value_q;
	logic signed [SAMPLE_WIDTH-1:0] lo_q;
	logic signed [SAMPLE_WIDTH-1:0] hi_q;
	logic                           vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= scan_vld_in;
			if (shift) begin
				value_q <= shift_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= (value_q < lo_in) ? value_q : lo_in;
		hi_q <= (value_q > hi_in) ? value_q : hi_in;
	end

	assign value    = value_q;
	assign scan_vld = vld_q;
	assign lo_out   = lo_q;
	assign hi_out   = hi_q;

endmodule

[design/ssm_window.sv]
// Sliding window: a row of ssm_cell instances, fill count, scan launch and the
// peak-to-peak threshold compare. Depends on ssm_pkg and ssm_cell.
`timescale 1ns / 1ps

module ssm_window
	import ssm_pkg::*;
#(
	parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic signed [SAMPLE_WIDTH-1:0] push_value,
	input  logic [DATA_W-1:0]              threshold,
	output ssm_win_stat_t                  stat
);

	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int CMP_W  = (SAMPLE_WIDTH + 1 > DATA_W) ? SAMPLE_WIDTH + 1 : DATA_W;
	localparam int LAST   = WINDOW_LEN - 1;

	logic signed [SAMPLE_WIDTH-1:0] cell_val [WINDOW_LEN];
	logic signed [SAMPLE_WIDTH-1:0] cell_lo  [WINDOW_LEN];
	logic signed [SAMPLE_WIDTH-1:0] cell_hi  [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]          cell_vld;

	logic [FILL_W-1:0]   fill_q;
	logic                start_q;
	logic                busy_q;
	logic                stable_q;
	logic                full;
	logic [SAMPLE_WIDTH:0] pp;
	logic                in_range;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		logic signed [SAMPLE_WIDTH-1:0] sh_in;
		logic                           sv_in;
		logic signed [SAMPLE_WIDTH-1:0] l_in;
		logic signed [SAMPLE_WIDTH-1:0] h_in;

		if (i == LAST) begin : g_tail
			assign sh_in = push_value;
		end else begin : g_body
			assign sh_in = cell_val[i+1];
		end

		if (i == 0) begin : g_head
			assign sv_in = start_q;
			assign l_in  = cell_val[0];
			assign h_in  = cell_val[0];
		end else begin : g_link
			assign sv_in = cell_vld[i-1];
			assign l_in  = cell_lo[i-1];
			assign h_in  = cell_hi[i-1];
		end

		ssm_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (push),
			.shift_in   (sh_in),
			.value      (cell_val[i]),
			.scan_vld_in(sv_in),
			.lo_in      (l_in),
			.hi_in      (h_in),
			.scan_vld   (cell_vld[i]),
			.lo_out     (cell_lo[i]),
			.hi_out     (cell_hi[i])
		);
	end

	assign full     = (fill_q == FILL_W'(WINDOW_LEN));
	assign pp       = {cell_hi[LAST][SAMPLE_WIDTH-1], cell_hi[LAST]}
	                - {cell_lo[LAST][SAMPLE_WIDTH-1], cell_lo[LAST]};
	assign in_range = (CMP_W'(pp) <= CMP_W'(threshold));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			start_q  <= 1'b0;
			busy_q   <= 1'b0;
			stable_q <= 1'b0;
		end else begin
			start_q <= push && full;
			if (push) begin
				if (!full) begin
					fill_q   <= FILL_W'(fill_q + 1'b1);
					stable_q <= 1'b0;
				end else begin
					busy_q <= 1'b1;
				end
			end
			if (cell_vld[LAST]) begin
				stable_q <= in_range;
				busy_q   <= 1'b0;
			end
		end
	end

	assign stat.full   = full;
	assign stat.busy   = busy_q;
	assign stat.stable = stable_q;

endmodule

[design/ssm_div.sv]
// Restoring divider for the finish average: one quotient bit per cycle,
// signed dividend, unsigned divisor, zero divisor gives zero. Depends on ssm_pkg.
`timescale 1ns / 1ps

module ssm_div
	import ssm_pkg::*;
#(
	parameter int CNT_W = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W);

	logic              run_q;
	logic              fin_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [SUM_W-1:0]  quo_q;
	logic              neg_q;
	logic              zero_q;
	logic [DATA_W-1:0] res_q;

	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic           ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && !start && (step_q == STEP_W'(SUM_W - 1));
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= STEP_W'(step_q + 1'b1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= dividend[SUM_W-1];
			quo_q  <= dividend[SUM_W-1] ? -dividend : dividend;
			rem_q  <= '0;
			den_q  <= divisor;
			zero_q <= (divisor == '0);
		end else if (run_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
		if (fin_q) begin
			res_q <= zero_q ? '0 : DATA_W'(neg_q ? -quo_q : quo_q);
		end
	end

	assign done     = done_q;
	assign quotient = res_q;

endmodule

[design/sample_stability_monitor.sv]
// Sample stability monitor. A command or sample transaction is taken only while the
// block is idle and yields exactly one result transaction. Start, stop, a sample with
// checking off, or a sample while the window is still filling goes straight to the result
// stage. A sample with the window full first waits while the min/max pair walks the row
// of window cells one cell per cycle before the threshold compare. Finish waits for the
// divider, which produces one quotient bit of the 48-bit sum per cycle.
// Depends on ssm_pkg, ssm_window, ssm_cell and ssm_div.
`timescale 1ns / 1ps

module sample_stability_monitor
	import ssm_pkg::*;
#(
	parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int MAX_COUNT    = MAX_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] sample_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     stable,
	output logic [DATA_W-1:0]        span,
	output logic signed [DATA_W-1:0] mean_value,
	output logic                     mean_valid,
	output logic                     count_overflow
);

	localparam int CNT_W = $clog2(MAX_COUNT + 1);
	localparam int SW    = SAMPLE_WIDTH;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WIN  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [DATA_W-1:0]    thr_q;
	logic                 chk_q;
	logic [1:0]           state_q;
	logic [1:0]           op_q;
	logic signed [SW-1:0] run_min_q;
	logic signed [SW-1:0] run_max_q;
	logic [DATA_W-1:0]    span_q;
	logic                 first_q;
	logic                 coll_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     count_q;
	logic                 ovf_q;

	logic                     out_valid_q;
	logic                     out_stable_q;
	logic [DATA_W-1:0]        out_span_q;
	logic signed [DATA_W-1:0] out_mean_q;
	logic                     out_mvalid_q;
	logic                     out_ovf_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic                 acc;
	logic                 samp;
	logic                 win_push;
	logic                 out_free;
	logic signed [SW-1:0] v;
	logic signed [SW-1:0] cur_min;
	logic signed [SW-1:0] cur_max;
	logic                 grow_hi;
	logic                 grow_lo;
	logic [SW:0]          diff_hi;
	logic [SW:0]          diff_lo;
	ssm_win_stat_t        stat;
	logic                 div_done;
	logic [DATA_W-1:0]    div_quo;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = thr_q;
			REG_CHECK:     prdata = {{(DATA_W-1){1'b0}}, chk_q};
			default:       prdata = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign samp     = acc && (opcode == OP_SAMPLE);
	assign win_push = samp && coll_q && chk_q;
	assign out_free = !out_valid_q || !out_stall;

	assign v       = SW'(sample_value);
	assign cur_min = first_q ? v : run_min_q;
	assign cur_max = first_q ? v : run_max_q;
	assign grow_hi = (v > cur_max);
	assign grow_lo = (v < cur_min);
	assign diff_hi = {v[SW-1], v} - {cur_min[SW-1], cur_min};
	assign diff_lo = {cur_max[SW-1], cur_max} - {v[SW-1], v};

	ssm_window #(
		.WINDOW_LEN  (WINDOW_LEN),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (win_push),
		.push_value(v),
		.threshold (thr_q),
		.stat      (stat)
	);

	ssm_div #(
		.CNT_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (acc && (opcode == OP_FINISH)),
		.dividend(sum_q),
		.divisor (count_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
			chk_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_THRESHOLD: thr_q <= pwdata;
				REG_CHECK:     chk_q <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= '0;
			run_max_q <= '0;
			span_q    <= '0;
			first_q   <= 1'b0;
			coll_q    <= 1'b0;
			sum_q     <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
		end else if (acc) begin
			unique case (opcode) inside
				OP_SAMPLE: begin
					if (first_q) begin
						run_min_q <= v;
						run_max_q <= v;
						first_q   <= 1'b0;
					end
					if (coll_q) begin
						if (count_q < CNT_W'(MAX_COUNT)) begin
							sum_q   <= sum_q + SUM_W'(v);
							count_q <= CNT_W'(count_q + 1'b1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (grow_hi) begin
							run_max_q <= v;
							span_q    <= DATA_W'(diff_hi);
						end else if (grow_lo) begin
							run_min_q <= v;
							span_q    <= DATA_W'(diff_lo);
						end
					end
				end
				OP_START: begin
					first_q <= 1'b1;
					coll_q  <= 1'b1;
					sum_q   <= '0;
					count_q <= '0;
					ovf_q   <= 1'b0;
					span_q  <= '0;
				end
				OP_STOP, OP_FINISH: begin
					coll_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SAMPLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						op_q <= opcode;
						if (win_push && stat.full) begin
							state_q <= ST_WIN;
						end else if (opcode == OP_FINISH) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_WIN: begin
					if (!stat.busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_stable_q <= stat.stable;
			out_span_q   <= span_q;
			out_mean_q   <= (op_q == OP_FINISH) ? div_quo : '0;
			out_mvalid_q <= (op_q == OP_FINISH);
			out_ovf_q    <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign stable         = out_stable_q;
	assign span           = out_span_q;
	assign mean_value     = out_mean_q;
	assign mean_valid     = out_mvalid_q;
	assign count_overflow = out_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_COUNT))
		else $error("sample count above capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CNT_W'(MAX_COUNT)))
		else $error("overflow flagged with room left in the counter");

	a_scan_in_win: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> (state_q == ST_WIN))
		else $error("window scan running outside its wait state");

	a_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_mvalid_q) |-> (out_mean_q == '0))
		else $error("nonzero mean on a result without the average");

endmodule
